/* hw/rtl/tcw_pkg.sv */
// Text console writer: shared types and constants.
// Screen geometry, field widths, command codes and the transaction structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths fixed by the transaction format
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] character;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/text_console_writer_top.sv */
// Text console writer top level: screen store, cursor and command sequencer.
// Depends on tcw_pkg and tcw_apb_regs.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      tcw_pkg::in_item_t
//   m_        out        m_valid / m_ready      tcw_pkg::out_item_t
//   apb       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// A character, an unused command or a read outside the screen goes from idle
// straight to the done state, a read inside the screen through a read state first.
// Screen rows sit in a ring addressed through a top-row offset, so a scroll
// only blanks one row, one cell at a time on the single memory write port.
// A clear sweeps every cell. After reset a clearing
// pass over every cell runs with s_ready low. One result can wait in the
// output register while the next transaction runs; that transaction then
// holds in its last cycle, with s_ready low, until m_ready frees the register.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  tcw_pkg::in_item_t     s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output tcw_pkg::out_item_t          m_data,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [tcw_pkg::PADDR_W-1:0] paddr,
    input  wire  [tcw_pkg::PDATA_W-1:0] pwdata,
    output logic [tcw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

    logic [ATTR_W-1:0] text_attr;

    logic [1:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic              sweep_res_reg, sweep_res_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    // Screen store
    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Cursor and address arithmetic
    logic              accept;
    logic              is_newline;
    logic              row_inc;
    logic              do_scroll;
    logic [COL_W-1:0]  wr_col;
    logic [ROW_W-1:0]  wr_row;
    logic [ROW_W:0]    cur_sum;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W:0]    rd_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic              rd_in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] top_base;
    logic              out_free;

    tcw_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .text_attr (text_attr)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Map logical rows onto the ring of physical rows
    assign cur_sum  = {1'b0, row_reg} + {1'b0, top_reg};
    assign cur_phys = (cur_sum >= (ROW_W+1)'(ROWS)) ?
                      ROW_W'(cur_sum - (ROW_W+1)'(ROWS)) : cur_sum[ROW_W-1:0];
    assign rd_sum   = {1'b0, s_data.read_row} + {1'b0, top_reg};
    assign rd_phys  = (rd_sum >= (ROW_W+1)'(ROWS)) ?
                      ROW_W'(rd_sum - (ROW_W+1)'(ROWS)) : rd_sum[ROW_W-1:0];
    assign cur_addr = ADDR_W'(cur_phys) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign rd_addr  = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(s_data.read_col);
    assign top_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);

    assign rd_in_range = (s_data.read_row < ROW_W'(ROWS)) &&
                         (s_data.read_col < COL_W'(COLUMNS));

    // Advance the cursor for a write command
    assign is_newline = (s_data.character == CHAR_NEWLINE);
    assign row_inc    = is_newline || (col_reg == COL_LAST);
    assign do_scroll  = row_inc && (row_reg == ROW_LAST);
    assign wr_col     = row_inc ? '0 : col_reg + COL_W'(1);
    assign wr_row     = (row_inc && !do_scroll) ? row_reg + ROW_W'(1) : row_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_res_next  = sweep_res_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = rd_addr;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next            = '0;
                    res_next.cursor_col = col_reg;
                    res_next.cursor_row = row_reg;
                    state_next          = ST_DONE;
                    case (s_data.command)
                        CMD_WRITE: begin
                            if (!is_newline) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {text_attr, s_data.character};
                            end
                            col_next            = wr_col;
                            row_next            = wr_row;
                            res_next.cursor_col = wr_col;
                            res_next.cursor_row = wr_row;
                            if (do_scroll) begin
                                // Old top row becomes the blank bottom row
                                res_next.scrolled = 1'b1;
                                top_next = (top_reg == ROW_LAST) ? '0 : top_reg + ROW_W'(1);
                                sweep_addr_next = top_base;
                                sweep_last_next = top_base + ADDR_W'(COLUMNS - 1);
                                sweep_res_next  = 1'b1;
                                state_next      = ST_SWEEP;
                            end
                        end
                        CMD_CLEAR: begin
                            col_next            = '0;
                            row_next            = '0;
                            top_next            = '0;
                            res_next.cursor_col = '0;
                            res_next.cursor_row = '0;
                            sweep_addr_next     = '0;
                            sweep_last_next     = CELL_LAST;
                            sweep_res_next      = 1'b1;
                            state_next          = ST_SWEEP;
                        end
                        CMD_READ: begin
                            if (rd_in_range) begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Zero one cell a cycle
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = '0;
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = sweep_res_reg ? ST_DONE : ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            ST_READ: begin
                res_next.cell_char = rdata_reg[CHAR_W-1:0];
                res_next.cell_attr = rdata_reg[CELL_W-1:CHAR_W];
                state_next         = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load the finished result, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= CELL_LAST;
            sweep_res_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_res_reg  <= sweep_res_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Screen store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Cursor and ring offset stay on the screen
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg < ROW_W'(ROWS)) && (top_reg < ROW_W'(ROWS)) && (col_reg < COL_W'(COLUMNS)))
        else $error("cursor or top row beyond the screen");

    // No store write while a read result or a finished result is pending
    a_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_DONE) |-> !mem_we)
        else $error("screen write outside idle or sweep");

    // A scrolling character starts a row blank sweep
    a_scroll_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == CMD_WRITE && do_scroll) |=>
        (state_reg == ST_SWEEP && sweep_last_reg - sweep_addr_reg == ADDR_W'(COLUMNS - 1)))
        else $error("scroll did not start a row sweep");

    // The sweep stays inside the store
    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (sweep_last_reg <= CELL_LAST && sweep_addr_reg <= sweep_last_reg))
        else $error("sweep address out of range");

    // A result is loaded only into a free output register
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg == ST_DONE) && state_reg == ST_IDLE) |-> m_valid_reg)
        else $error("finished result lost");

endmodule

`default_nettype wire

/* hw/rtl/tcw_apb_regs.sv */
// Text console writer: APB register block holding the text attribute.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_apb_regs (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [tcw_pkg::PADDR_W-1:0] paddr,
    input  wire  [tcw_pkg::PDATA_W-1:0] pwdata,
    output logic [tcw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [tcw_pkg::ATTR_W-1:0]  text_attr
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic              sel_attr;

    assign pready   = 1'b1;
    assign sel_attr = (paddr[2] == REG_TEXT_ATTR);

    // Take the low byte on a completed write to the attribute register
    always_comb begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && sel_attr) begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else begin
            attr_reg <= attr_next;
        end
    end

    // Return the attribute, zero elsewhere
    always_comb begin
        prdata = '0;
        if (sel_attr) begin
            prdata = PDATA_W'(attr_reg);
        end
    end

    assign text_attr = attr_reg;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for text_console_writer_top: a random and directed command stream
// is checked against a cycle-free model of the screen, the cursor and the attribute.
// Depends on tcw_pkg and the text_console_writer_top RTL.
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 400;
    localparam int MAX_PRINTED   = 50;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic              pready;

    // Console model state
    logic [CELL_W-1:0] screen_model [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr_model;

    in_item_t          queued_commands [$];
    out_item_t         predicted_results [$];

    int send_gap_pct;
    int recv_stall_pct;
    int text_left;
    int mismatches;
    int stalled_cycles;
    int n_writes;
    int n_reads;
    int n_clears;
    int n_scrolls;
    int n_attr_writes;

    text_console_writer_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Advance the console model by one command and return the result it produces
    function automatic out_item_t predict_console(input in_item_t item);
        out_item_t res;
        res = '0;
        case (item.command)
            CMD_WRITE: begin
                if (item.character == CHAR_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_model, item.character};
                    if (cur_col >= COLUMNS - 1) begin
                        cur_col = 0;
                        cur_row++;
                    end else begin
                        cur_col++;
                    end
                end
                // Scroll up one row and blank the bottom row
                if (cur_row >= ROWS) begin
                    cur_row = ROWS - 1;
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_model[i] = '0;
                    res.scrolled = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = '0;
                cur_col = 0;
                cur_row = 0;
            end
            CMD_READ: begin
                if (int'(item.read_row) < ROWS && int'(item.read_col) < COLUMNS)
                    {res.cell_attr, res.cell_char} =
                        screen_model[int'(item.read_row) * COLUMNS + int'(item.read_col)];
            end
            default: ;
        endcase
        res.cursor_col = cur_col[COL_W-1:0];
        res.cursor_row = cur_row[ROW_W-1:0];
        return res;
    endfunction

    function automatic in_item_t make_command(input logic [1:0] cmd, input int ch,
                                              input int row, input int col);
        in_item_t item;
        item.command   = cmd;
        item.character = ch[CHAR_W-1:0];
        item.read_row  = row[ROW_W-1:0];
        item.read_col  = col[COL_W-1:0];
        return item;
    endfunction

    // Mostly lines of text of random length, ended by a newline, with reads mixed in;
    // the rest is stray bytes, unused commands and the odd clear
    function automatic in_item_t random_command();
        in_item_t item;
        int pick;
        int span;
        item = make_command(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 31),
                            $urandom_range(0, 127));
        pick = $urandom_range(0, 999);
        if (pick < 3) begin
            item.command = CMD_CLEAR;
        end else if (pick < 25) begin
            item.command = CMD_UNUSED;
        end else if (pick < 260) begin
            item.command = CMD_READ;
            if (pick < 230) begin
                item.read_row = ROW_W'($urandom_range(0, ROWS - 1));
                item.read_col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        end else if (pick >= 300) begin
            if (text_left == 0) begin
                item.character = CHAR_NEWLINE;
                span = $urandom_range(0, 99);
                if (span < 80)
                    text_left = $urandom_range(0, 5);
                else if (span < 95)
                    text_left = $urandom_range(6, 40);
                else
                    text_left = $urandom_range(75, 100);
            end else begin
                while (item.character == CHAR_NEWLINE)
                    item.character = CHAR_W'($urandom_range(0, 255));
                text_left--;
            end
        end
        return item;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_text_attr(input logic [ATTR_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TEXT_ATTR, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_model = value;
        n_attr_writes++;
    endtask

    // Hold until every queued command is accepted and every result has come back
    task automatic wait_idle();
        while (queued_commands.size() != 0 || s_valid || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Driver: present the next queued command, holding it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_results.push_back(predict_console(s_data));
                if (s_data.command == CMD_WRITE)
                    n_writes++;
                else if (s_data.command == CMD_READ)
                    n_reads++;
                else if (s_data.command == CMD_CLEAR)
                    n_clears++;
            end
            if (!s_valid || s_ready) begin
                if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= queued_commands.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and compare each result with the oldest prediction
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no command outstanding", int'(m_data), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (want.scrolled)
                        n_scrolls++;
                    if (m_data.cell_char !== want.cell_char)
                        report_mismatch("cell_char", m_data.cell_char, want.cell_char);
                    if (m_data.cell_attr !== want.cell_attr)
                        report_mismatch("cell_attr", m_data.cell_attr, want.cell_attr);
                    if (m_data.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", m_data.cursor_col, want.cursor_col);
                    if (m_data.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", m_data.cursor_row, want.cursor_row);
                    if (m_data.scrolled !== want.scrolled)
                        report_mismatch("scrolled", m_data.scrolled, want.scrolled);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;
        cur_col        = 0;
        cur_row        = 0;
        attr_model     = ATTR_RESET;
        text_left      = 0;
        mismatches     = 0;
        stalled_cycles = 0;
        n_writes       = 0;
        n_reads        = 0;
        n_clears       = 0;
        n_scrolls      = 0;
        n_attr_writes  = 0;
        send_gap_pct   = 29;
        recv_stall_pct = 82;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset contents, character zero, all-ones byte, reads off the screen,
        // the unused command, newline, and a clear that keeps the attribute
        queued_commands.push_back(make_command(CMD_READ, 0, 0, 0));
        queued_commands.push_back(make_command(CMD_WRITE, 8'h41, 0, 0));
        queued_commands.push_back(make_command(CMD_WRITE, 8'h00, 31, 127));
        queued_commands.push_back(make_command(CMD_WRITE, 8'hFF, 0, 0));
        queued_commands.push_back(make_command(CMD_READ, 0, 0, 0));
        queued_commands.push_back(make_command(CMD_READ, 8'hFF, 0, 1));
        queued_commands.push_back(make_command(CMD_READ, 0, 0, 2));
        queued_commands.push_back(make_command(CMD_READ, 0, ROWS - 1, COLUMNS - 1));
        queued_commands.push_back(make_command(CMD_READ, 0, ROWS, 0));
        queued_commands.push_back(make_command(CMD_READ, 0, 0, COLUMNS));
        queued_commands.push_back(make_command(CMD_READ, 0, 31, 127));
        queued_commands.push_back(make_command(CMD_UNUSED, 8'hFF, 31, 127));
        queued_commands.push_back(make_command(CMD_WRITE, CHAR_NEWLINE, 0, 0));
        queued_commands.push_back(make_command(CMD_WRITE, 8'h7E, 0, 0));
        queued_commands.push_back(make_command(CMD_READ, 0, 1, 0));
        queued_commands.push_back(make_command(CMD_CLEAR, 8'hFF, 31, 127));
        queued_commands.push_back(make_command(CMD_READ, 0, 0, 0));
        queued_commands.push_back(make_command(CMD_READ, 0, 1, 0));
        queued_commands.push_back(make_command(CMD_WRITE, 8'h55, 0, 0));
        queued_commands.push_back(make_command(CMD_READ, 0, 0, 0));
        wait_idle();

        // Random phase: sender gaps, receiver mostly stalled, brightest attribute
        write_text_attr(8'hFF);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queued_commands.push_back(random_command());
        wait_idle();

        // Random phase: roles swapped, attribute zero
        send_gap_pct   = 82;
        recv_stall_pct = 29;
        write_text_attr(8'h00);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queued_commands.push_back(random_command());
        wait_idle();

        // Random phase: full throughput, random attribute
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_text_attr(ATTR_W'($urandom_range(1, 254)));
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queued_commands.push_back(random_command());
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predicted_results.size() != 0)
            report_mismatch("results never returned", 0, predicted_results.size());

        $display("Ran %0d writes, %0d cell reads and %0d clears; %0d writes scrolled the screen.",
                 n_writes, n_reads, n_clears, n_scrolls);
        $display("Attribute set %0d times across three handshake pacing modes.", n_attr_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
